FILE: hdl/frac_pkg.sv
// Shared types and constants for the fraction arithmetic and reduction block.
// Holds the request and result words and the controller to datapath interface.
// No dependencies.
`default_nettype none

package frac_pkg;

  localparam int DATA_W = 36;
  localparam int MUL_W  = 18;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] num_a;
    logic signed [15:0] den_a;
    logic signed [15:0] num_b;
    logic signed [15:0] den_b;
  } req_t;

  typedef struct packed {
    logic signed [33:0] num_r;
    logic signed [31:0] den_r;
    logic               err;
  } rsp_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_DADB_K,
    DP_GCD_DIV,
    DP_GCD_WB,
    DP_L_DIV,
    DP_L_WB,
    DP_KA_DIV,
    DP_KB_DIV,
    DP_K_WB,
    DP_PA,
    DP_PB_ADD,
    DP_PB_SUB,
    DP_MUL_NN,
    DP_MUL_DD,
    DP_MUL_ND,
    DP_MUL_DN,
    DP_GCD2_INIT,
    DP_NG_DIV,
    DP_DG_DIV,
    DP_NUM_WB,
    DP_DEN_WB,
    DP_SET_ERR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } frac_cmd_t;

  typedef struct packed {
    logic [1:0] opc;
    logic       err_in;
    logic       x_zero;
    logic       y_zero;
    logic       div_done;
  } frac_sts_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHK,
    ST_MDD,
    ST_G1_TEST,
    ST_G1_WAIT,
    ST_L,
    ST_L_WAIT,
    ST_KA,
    ST_KA_WAIT,
    ST_PA,
    ST_KB,
    ST_KB_WAIT,
    ST_PB,
    ST_M1,
    ST_M2,
    ST_G2_INIT,
    ST_G2_TEST,
    ST_G2_WAIT,
    ST_NG,
    ST_NG_WAIT,
    ST_DG,
    ST_DG_WAIT,
    ST_ERR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/fraction_arith_reduce_top.sv
// Top level of the fraction arithmetic and reduction block.
// Depends on frac_pkg, frac_ctrl and frac_dp.
`default_nettype none

// A word is taken when start is high and busy is low; busy then stays high until
// the result word has been shown. The result is on rsp for exactly one cycle with
// valid high and cannot be stalled. The work is done by passes through the shared
// one-bit-per-cycle divider: add and subtract use it for the denominator gcd
// steps and three divisions, and all operations use it for the reducing gcd steps
// and two final divisions.
module fraction_arith_reduce_top #(
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire frac_pkg::req_t req,
  output logic                busy,
  output logic                valid,
  output frac_pkg::rsp_t      rsp
);
  import frac_pkg::*;

  frac_cmd_t cmd;
  frac_sts_t sts;

  frac_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .valid (valid)
  );

  frac_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

FILE: hdl/frac_div.sv
// Iterative signed divider with truncating quotient and remainder, one bit per cycle.
// Depends on frac_pkg for the data width.
`default_nettype none

module frac_div (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [frac_pkg::DATA_W-1:0] a,
  input  wire logic signed [frac_pkg::DATA_W-1:0] b,
  output logic signed [frac_pkg::DATA_W-1:0]      q,
  output logic signed [frac_pkg::DATA_W-1:0]      r,
  output logic                                    done
);
  import frac_pkg::*;

  localparam int CW = $clog2(DATA_W + 1);

  logic            busy;
  logic [CW-1:0]   cnt;
  logic [DATA_W-1:0] rem, quo, ub;
  logic            qneg, rneg;
  logic [DATA_W:0] rs, diff;
  logic [DATA_W-1:0] abs_a, abs_b;

  assign abs_a = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
  assign abs_b = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
  assign rs    = {rem, quo[DATA_W-1]};
  assign diff  = rs - {1'b0, ub};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DATA_W);
        rem  <= '0;
        quo  <= abs_a;
        ub   <= abs_b;
        qneg <= a[DATA_W-1] ^ b[DATA_W-1];
        rneg <= a[DATA_W-1];
      end else if (busy) begin
        if (!diff[DATA_W]) begin
          rem <= diff[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b1};
        end else begin
          rem <= rs[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign q = qneg ? -$signed(quo) : $signed(quo);
  assign r = rneg ? -$signed(rem) : $signed(rem);

endmodule

`default_nettype wire

FILE: hdl/frac_dp.sv
// Datapath: operand registers, one shared 18x18 multiplier and the iterative divider.
// Depends on frac_pkg and frac_div.
`default_nettype none

module frac_dp #(
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire frac_pkg::req_t    req,
  input  wire frac_pkg::frac_cmd_t cmd,
  output frac_pkg::frac_sts_t    sts,
  output frac_pkg::rsp_t         rsp
);
  import frac_pkg::*;

  localparam int SH = 64 - VALUE_WIDTH;

  function automatic logic signed [MUL_W-1:0] sext(input logic [15:0] f);
    logic signed [63:0] t;
    t = signed'({48'b0, f} << SH);
    t = t >>> SH;
    return t[MUL_W-1:0];
  endfunction

  logic [1:0]                opc;
  logic signed [MUL_W-1:0]   na, da, nb, db;
  logic signed [DATA_W-1:0]  x, y, k, num, den;
  logic                      err;

  logic signed [MUL_W-1:0]   ma, mb;
  logic signed [DATA_W-1:0]  prod;
  logic                      div_start;
  logic signed [DATA_W-1:0]  div_a, div_b, div_q, div_r;
  logic                      div_done;

  always_comb begin
    ma = na;
    mb = k[MUL_W-1:0];
    case (cmd.op)
      DP_MUL_DADB_K: begin ma = da; mb = db; end
      DP_PB_ADD,
      DP_PB_SUB:     begin ma = nb; mb = k[MUL_W-1:0]; end
      DP_MUL_NN:     begin ma = na; mb = nb; end
      DP_MUL_DD:     begin ma = da; mb = db; end
      DP_MUL_ND:     begin ma = na; mb = db; end
      DP_MUL_DN:     begin ma = da; mb = nb; end
      default:       begin ma = na; mb = k[MUL_W-1:0]; end
    endcase
  end

  assign prod = DATA_W'(ma * mb);

  always_comb begin
    div_start = 1'b1;
    div_a     = y;
    div_b     = x;
    case (cmd.op)
      DP_GCD_DIV: begin div_a = y;   div_b = x; end
      DP_L_DIV:   begin div_a = k;   div_b = y; end
      DP_KA_DIV:  begin div_a = den; div_b = DATA_W'(da); end
      DP_KB_DIV:  begin div_a = den; div_b = DATA_W'(db); end
      DP_NG_DIV:  begin div_a = num; div_b = y; end
      DP_DG_DIV:  begin div_a = den; div_b = y; end
      default:    div_start = 1'b0;
    endcase
  end

  frac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .q     (div_q),
    .r     (div_r),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        opc <= req.op;
        na  <= sext(req.num_a);
        da  <= sext(req.den_a);
        nb  <= sext(req.num_b);
        db  <= sext(req.den_b);
        err <= 1'b0;
      end
      DP_MUL_DADB_K: begin
        k <= prod;
        x <= DATA_W'(da);
        y <= DATA_W'(db);
      end
      DP_GCD_WB: begin
        y <= x;
        x <= div_r;
      end
      DP_L_WB:   den <= div_q;
      DP_K_WB:   k   <= div_q;
      DP_PA:     num <= prod;
      DP_PB_ADD: num <= num + prod;
      DP_PB_SUB: num <= num - prod;
      DP_MUL_NN,
      DP_MUL_ND: num <= prod;
      DP_MUL_DD,
      DP_MUL_DN: den <= prod;
      DP_GCD2_INIT: begin
        x <= num;
        y <= den;
      end
      DP_NUM_WB: num <= div_q;
      DP_DEN_WB: den <= div_q;
      DP_SET_ERR: begin
        err <= 1'b1;
        num <= '0;
        den <= '0;
      end
      default: ;
    endcase
  end

  assign sts.opc      = opc;
  assign sts.err_in   = (da == '0) || (db == '0) || ((opc == OP_DIV) && (nb == '0));
  assign sts.x_zero   = (x == '0);
  assign sts.y_zero   = (y == '0);
  assign sts.div_done = div_done;

  assign rsp.num_r = num[33:0];
  assign rsp.den_r = den[31:0];
  assign rsp.err   = err;

endmodule

`default_nettype wire

FILE: hdl/frac_ctrl.sv
// Controller state machine that sequences the datapath for one operation.
// Depends on frac_pkg.
`default_nettype none

module frac_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire frac_pkg::frac_sts_t sts,
  output frac_pkg::frac_cmd_t      cmd,
  output logic                     busy,
  output logic                     valid
);
  import frac_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = DP_NOP;
    busy       = (state != ST_IDLE);
    valid      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.op     = DP_LOAD;
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts.err_in) begin
          state_next = ST_ERR;
        end else if (sts.opc == OP_ADD || sts.opc == OP_SUB) begin
          state_next = ST_MDD;
        end else begin
          state_next = ST_M1;
        end
      end
      ST_MDD: begin
        cmd.op     = DP_MUL_DADB_K;
        state_next = ST_G1_TEST;
      end
      ST_G1_TEST: begin
        if (sts.x_zero) begin
          state_next = ST_L;
        end else begin
          cmd.op     = DP_GCD_DIV;
          state_next = ST_G1_WAIT;
        end
      end
      ST_G1_WAIT: begin
        if (sts.div_done) begin
          cmd.op     = DP_GCD_WB;
          state_next = ST_G1_TEST;
        end
      end
      ST_L: begin
        cmd.op     = DP_L_DIV;
        state_next = ST_L_WAIT;
      end
      ST_L_WAIT: begin
        if (sts.div_done) begin
          cmd.op     = DP_L_WB;
          state_next = ST_KA;
        end
      end
      ST_KA: begin
        cmd.op     = DP_KA_DIV;
        state_next = ST_KA_WAIT;
      end
      ST_KA_WAIT: begin
        if (sts.div_done) begin
          cmd.op     = DP_K_WB;
          state_next = ST_PA;
        end
      end
      ST_PA: begin
        cmd.op     = DP_PA;
        state_next = ST_KB;
      end
      ST_KB: begin
        cmd.op     = DP_KB_DIV;
        state_next = ST_KB_WAIT;
      end
      ST_KB_WAIT: begin
        if (sts.div_done) begin
          cmd.op     = DP_K_WB;
          state_next = ST_PB;
        end
      end
      ST_PB: begin
        cmd.op     = (sts.opc == OP_ADD) ? DP_PB_ADD : DP_PB_SUB;
        state_next = ST_G2_INIT;
      end
      ST_M1: begin
        cmd.op     = (sts.opc == OP_MUL) ? DP_MUL_NN : DP_MUL_ND;
        state_next = ST_M2;
      end
      ST_M2: begin
        cmd.op     = (sts.opc == OP_MUL) ? DP_MUL_DD : DP_MUL_DN;
        state_next = ST_G2_INIT;
      end
      ST_G2_INIT: begin
        cmd.op     = DP_GCD2_INIT;
        state_next = ST_G2_TEST;
      end
      ST_G2_TEST: begin
        if (!sts.x_zero) begin
          cmd.op     = DP_GCD_DIV;
          state_next = ST_G2_WAIT;
        end else if (sts.y_zero) begin
          state_next = ST_ERR;
        end else begin
          state_next = ST_NG;
        end
      end
      ST_G2_WAIT: begin
        if (sts.div_done) begin
          cmd.op     = DP_GCD_WB;
          state_next = ST_G2_TEST;
        end
      end
      ST_NG: begin
        cmd.op     = DP_NG_DIV;
        state_next = ST_NG_WAIT;
      end
      ST_NG_WAIT: begin
        if (sts.div_done) begin
          cmd.op     = DP_NUM_WB;
          state_next = ST_DG;
        end
      end
      ST_DG: begin
        cmd.op     = DP_DG_DIV;
        state_next = ST_DG_WAIT;
      end
      ST_DG_WAIT: begin
        if (sts.div_done) begin
          cmd.op     = DP_DEN_WB;
          state_next = ST_DONE;
        end
      end
      ST_ERR: begin
        cmd.op     = DP_SET_ERR;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        valid      = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: verif/fraction_arith_reduce_top_tb.sv
// Testbench for fraction_arith_reduce_top: a directed table, then random words,
// all checked against a behavioral model of the reduced fraction arithmetic.
// Depends on frac_pkg and the fraction_arith_reduce_top RTL.
`default_nettype none

module fraction_arith_reduce_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import frac_pkg::*;

  localparam int  RANDOM_WORDS = 1880;
  localparam int  QUIET_TAIL   = 200;
  localparam longint CYCLE_LIMIT = 30_000_000;

  typedef struct {
    req_t req;
    bit   fixed;
    rsp_t rsp;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic valid;
  rsp_t rsp;

  rsp_t   pending_q[$];
  int     mismatches = 0;
  int     results_seen = 0;
  int     err_seen = 0;
  longint cycles = 0;
  int     op_count[4];

  fraction_arith_reduce_top DUT (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .valid(valid), .rsp(rsp)
  );

  always #1 clk = ~clk;

  // Truncating quotient; dividing by minus one is a plain negation.
  function automatic longint trunc_quot(longint x, longint y);
    if (y == -1) return -x;
    return x / y;
  endfunction

  // Euclid with the truncating remainder, so the result may come out negative.
  function automatic longint euclid_gcd(longint x, longint y);
    longint t;
    while (x != 0) begin
      t = (x == 1 || x == -1) ? 0 : y % x;
      y = x;
      x = t;
    end
    return y;
  endfunction

  function automatic rsp_t reduce_fraction(req_t r);
    longint na, da, nb, db, num, den, l, g;
    rsp_t   o;
    na = r.num_a;
    da = r.den_a;
    nb = r.num_b;
    db = r.den_b;
    o = '0;
    if (da == 0 || db == 0 || (r.op == OP_DIV && nb == 0)) begin
      o.err = 1'b1;
      return o;
    end
    case (r.op)
      OP_ADD, OP_SUB: begin
        l = trunc_quot(da * db, euclid_gcd(da, db));
        num = (r.op == OP_ADD) ? na * trunc_quot(l, da) + nb * trunc_quot(l, db)
                               : na * trunc_quot(l, da) - nb * trunc_quot(l, db);
        den = l;
      end
      OP_MUL: begin
        num = na * nb;
        den = da * db;
      end
      default: begin
        num = na * db;
        den = da * nb;
      end
    endcase
    g = euclid_gcd(num, den);
    if (g == 0) begin
      o.err = 1'b1;
      return o;
    end
    o.num_r = 34'(trunc_quot(num, g));
    o.den_r = 32'(trunc_quot(den, g));
    return o;
  endfunction

  function automatic logic [15:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 16'($signed($urandom_range(0, 128)) - 64);
    if (sel < 68) begin
      case ($urandom_range(0, 4))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'hffff;
        3: return 16'h0001;
        default: return 16'h0000;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic req_t random_word();
    req_t r;
    r.op    = 2'($urandom_range(0, 3));
    r.num_a = pick_value();
    r.den_a = pick_value();
    r.num_b = pick_value();
    r.den_b = pick_value();
    return r;
  endfunction

  // Holds start until the word is taken, then logs what the block owes us.
  task automatic send_word(req_t r);
    req   <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_q.push_back(reduce_fraction(r));
    op_count[r.op]++;
  endtask

  task automatic maybe_gap(bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && valid) begin
      results_seen++;
      if (rsp.err) err_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: result word with nothing pending, got %h", $time, rsp);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        if (rsp.num_r !== want.num_r || rsp.den_r !== want.den_r || rsp.err !== want.err) begin
          $display("%0t: expected num %0d den %0d err %0b, got num %0d den %0d err %0b",
                   $time, want.num_r, want.den_r, want.err, rsp.num_r, rsp.den_r, rsp.err);
          mismatches++;
        end
      end
    end
  end

  vec_t table_q[$];

  task automatic add_row(logic [1:0] op, int na, int da, int nb, int db,
                         bit fixed = 0, rsp_t r = '0);
    vec_t v;
    v.req = '{op, 16'(na), 16'(da), 16'(nb), 16'(db)};
    v.fixed = fixed;
    v.rsp = r;
    table_q.push_back(v);
  endtask

  initial begin
    rsp_t want;
    // Zero denominators on either side, and a zero divisor on divide.
    add_row(OP_ADD, 1, 0, 1, 1, 1, '{34'd0, 32'd0, 1'b1});
    add_row(OP_SUB, 1, 1, 1, 0, 1, '{34'd0, 32'd0, 1'b1});
    add_row(OP_MUL, 5, 0, 3, 0, 1, '{34'd0, 32'd0, 1'b1});
    add_row(OP_DIV, 3, 4, 0, 7, 1, '{34'd0, 32'd0, 1'b1});
    add_row(OP_ADD, 1, 2, 1, 2, 1, '{34'sd1, 32'sd1, 1'b0});
    add_row(OP_MUL, 3, 1, 1, 1, 1, '{34'sd3, 32'sd1, 1'b0});
    add_row(OP_DIV, 0, 5, 7, 3);
    add_row(OP_SUB, 3, 4, 3, 4);
    add_row(OP_ADD, -1, 3, 1, -6);
    add_row(OP_SUB, 5, -7, -2, 9);
    add_row(OP_MUL, -32768, -32768, -32768, -32768);
    add_row(OP_MUL, 32767, -32768, 32767, 1);
    add_row(OP_DIV, -32768, 32767, -32768, -1);
    add_row(OP_ADD, 32767, 32767, 32767, 32766);
    add_row(OP_SUB, -32768, 32767, 32767, -32768);
    add_row(OP_ADD, -32768, -1, -32768, -1);
    add_row(OP_DIV, 32767, -32768, -1, 32767);
    add_row(OP_MUL, 0, -1, 0, -32768);
    add_row(OP_SUB, 12, 18, -4, 27);
    add_row(OP_DIV, -6, -9, 4, -15);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_q[i]) begin
      send_word(table_q[i].req);
      if (table_q[i].fixed) begin
        want = pending_q.pop_back();
        if (want !== table_q[i].rsp) begin
          $display("%0t: expected row %0d model %h, typed %h", $time, i, want,
                   table_q[i].rsp);
          mismatches++;
        end
        pending_q.push_back(table_q[i].rsp);
      end
      maybe_gap(1);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      send_word(random_word());
      if (n == RANDOM_WORDS / 2) begin
        // Let the block drain completely before going on.
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end else begin
        maybe_gap(n < RANDOM_WORDS - QUIET_TAIL && n > 100);
      end
    end
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Covered %0d result words (%0d error words) in %0d cycles", results_seen,
             err_seen, cycles);
    $display("Words per op: add %0d, sub %0d, mul %0d, div %0d", op_count[0],
             op_count[1], op_count[2], op_count[3]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
